FILE: rtl/rht_pkg.sv
`timescale 1ns / 1ps
package rht_pkg;

  localparam int OP_W     = 3;
  localparam int ID_W     = 32;
  localparam int TYPE_W   = 4;
  localparam int STATE_W  = 2;
  localparam int STATUS_W = 2;
  localparam int REFS_W   = 16;
  localparam int LIVE_W   = 5;

  localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd1;
  localparam logic [OP_W-1:0] OP_RETAIN   = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE  = 3'd3;
  localparam logic [OP_W-1:0] OP_DESTROY  = 3'd4;
  localparam logic [OP_W-1:0] OP_ACTIVATE = 3'd5;
  localparam logic [OP_W-1:0] OP_SUSPEND  = 3'd6;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;

  localparam logic [STATE_W-1:0] OBJ_CREATED   = 2'd0;
  localparam logic [STATE_W-1:0] OBJ_ACTIVE    = 2'd1;
  localparam logic [STATE_W-1:0] OBJ_SUSPENDED = 2'd2;
  localparam logic [STATE_W-1:0] OBJ_GONE      = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;
    logic [TYPE_W-1:0]   result_type;
    logic [STATE_W-1:0]  result_state;
    logic [REFS_W-1:0]   result_refs;
    logic                freed;
    logic [LIVE_W-1:0]   live_count;
  } rsp_t;

endpackage

FILE: rtl/rht_req_if.sv
`timescale 1ns / 1ps
interface rht_req_if;
  import rht_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ID_W-1:0]   object_id;
  logic [TYPE_W-1:0] object_type;

  modport source (output valid, output opcode, output object_id, output object_type,
                  input ready);
  modport sink (input valid, input opcode, input object_id, input object_type,
                output ready);
endinterface

FILE: rtl/rht_rsp_if.sv
`timescale 1ns / 1ps
interface rht_rsp_if;
  import rht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     result_id;
  logic [TYPE_W-1:0]   result_type;
  logic [STATE_W-1:0]  result_state;
  logic [REFS_W-1:0]   result_refs;
  logic                freed;
  logic [LIVE_W-1:0]   live_count;

  modport source (output valid, output status, output result_id, output result_type,
                  output result_state, output result_refs, output freed,
                  output live_count, input ready);
  modport sink (input valid, input status, input result_id, input result_type,
                input result_state, input result_refs, input freed,
                input live_count, output ready);
endinterface

FILE: rtl/refcounted_object_handle_table.sv
`timescale 1ns / 1ps
// Reference-counted handle table of SLOTS object slots held in registers. At acceptance of
// a request every slot id is compared with the request id and tested for free in parallel,
// and the results are registered; in the execute state the first match or free slot is
// picked and its read-modify-write is done, loading the response register. A further
// request is accepted only once that update is done; the update waits while a previous
// response is still held. Reset clears the whole table at once, with no clearing pass.
module refcounted_object_handle_table #(
  parameter int SLOTS    = 16,
  parameter int REF_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  rht_req_if.sink   req,
  rht_rsp_if.source rsp
);
  import rht_pkg::*;

  cmd_t cmd;
  rsp_t rsp_data;

  rht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  rht_dp #(
    .SLOTS    (SLOTS),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (req.opcode),
    .object_id   (req.object_id),
    .object_type (req.object_type),
    .rsp_data    (rsp_data)
  );

  assign rsp.status       = rsp_data.status;
  assign rsp.result_id    = rsp_data.result_id;
  assign rsp.result_type  = rsp_data.result_type;
  assign rsp.result_state = rsp_data.result_state;
  assign rsp.result_refs  = rsp_data.result_refs;
  assign rsp.freed        = rsp_data.freed;
  assign rsp.live_count   = rsp_data.live_count;

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while previous one in progress");

  a_exec_not_stalled: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> (!rsp.valid || rsp.ready))
    else $error("response register overwritten while held");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != STS_OK) |->
      (rsp.result_id == '0 && !rsp.freed && rsp.result_state == OBJ_GONE))
    else $error("failed response carries object data");

  a_freed_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.freed) |->
      (rsp.result_id == '0 && rsp.result_refs == '0 && rsp.status == STS_OK))
    else $error("freed response carries object data");
endmodule

FILE: rtl/rht_ctrl.sv
`timescale 1ns / 1ps
module rht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rht_pkg::cmd_t cmd
);
  import rht_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_comb begin
    cmd.capture = in_valid && in_ready;
    // update only once the response register is free
    cmd.exec    = (state == S_EXEC) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state    <= S_EXEC;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
          if (out_valid && out_ready) out_valid <= 1'b0;
        end
        S_EXEC: begin
          if (cmd.exec) begin
            state     <= S_IDLE;
            in_ready  <= 1'b1;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

FILE: rtl/rht_dp.sv
`timescale 1ns / 1ps
module rht_dp #(
  parameter int SLOTS    = 16,
  parameter int REF_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rht_pkg::cmd_t              cmd,
  input  logic [rht_pkg::OP_W-1:0]   opcode,
  input  logic [rht_pkg::ID_W-1:0]   object_id,
  input  logic [rht_pkg::TYPE_W-1:0] object_type,
  output rht_pkg::rsp_t              rsp_data
);
  import rht_pkg::*;

  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);
  localparam logic [CNT_W-1:0]    CNT_ONE = CNT_W'(1);

  logic [ID_W-1:0]     slot_id    [SLOTS];
  logic [TYPE_W-1:0]   slot_type  [SLOTS];
  logic [STATE_W-1:0]  slot_state [SLOTS];
  logic [REF_BITS-1:0] slot_refs  [SLOTS];
  logic [CNT_W-1:0]    live_objects;
  logic [ID_W-1:0]     next_id;

  // captured request and compare vectors
  logic [OP_W-1:0]   req_op;
  logic [TYPE_W-1:0] req_type;
  logic [SLOTS-1:0]  match_vec, free_vec;
  logic [SLOTS-1:0]  match_vec_next, free_vec_next;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_vec_next[i] = (slot_id[i] == object_id) && (object_id != '0);
      free_vec_next[i]  = (slot_id[i] == '0);
    end
  end

  logic [IDX_W-1:0] match_idx, free_idx;
  logic             match_any, free_any;

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) match_idx = IDX_W'(i);
      if (free_vec[i])  free_idx  = IDX_W'(i);
    end
    match_any = |match_vec;
    free_any  = |free_vec;
  end

  logic [IDX_W-1:0]    idx;
  logic                wr;
  logic [ID_W-1:0]     n_id;
  logic [TYPE_W-1:0]   n_type;
  logic [STATE_W-1:0]  n_state;
  logic [REF_BITS-1:0] n_refs;
  logic [CNT_W-1:0]    live_next;
  logic [ID_W-1:0]     next_id_next;
  logic [STATUS_W-1:0] sts;
  logic                fr;
  logic [31:0]         refs_wide, live_wide;

  always_comb begin
    idx          = match_idx;
    wr           = 1'b0;
    n_id         = slot_id[match_idx];
    n_type       = slot_type[match_idx];
    n_state      = slot_state[match_idx];
    n_refs       = slot_refs[match_idx];
    live_next    = live_objects;
    next_id_next = next_id;
    sts          = STS_OK;
    fr           = 1'b0;
    unique case (req_op)
      OP_CREATE: begin
        idx = free_idx;
        if (next_id != '0 && free_any) begin
          wr           = 1'b1;
          n_id         = next_id;
          n_type       = req_type;
          n_state      = OBJ_CREATED;
          n_refs       = REF_ONE;
          live_next    = live_objects + CNT_ONE;
          next_id_next = next_id + ID_W'(1);
        end else begin
          sts = STS_FULL;
        end
      end
      OP_QUERY, OP_RETAIN, OP_RELEASE, OP_DESTROY, OP_ACTIVATE, OP_SUSPEND: begin
        if (!match_any) begin
          sts = STS_NOT_FOUND;
        end else begin
          wr = 1'b1;
          unique case (req_op)
            OP_RETAIN:   if (n_refs != REF_MAX) n_refs = n_refs + REF_ONE;
            OP_RELEASE:  begin
              if (n_refs == REF_ONE) fr = 1'b1;
              else if (n_refs != '0) n_refs = n_refs - REF_ONE;
            end
            OP_DESTROY:  fr = 1'b1;
            OP_ACTIVATE: n_state = OBJ_ACTIVE;
            OP_SUSPEND:  n_state = OBJ_SUSPENDED;
            default:     wr = 1'b0;
          endcase
          if (fr) begin
            n_id    = '0;
            n_type  = '0;
            n_state = OBJ_GONE;
            n_refs  = '0;
            if (live_objects != '0) live_next = live_objects - CNT_ONE;
          end
        end
      end
      default: sts = STS_NOT_FOUND;
    endcase
    refs_wide = 32'(n_refs);
    live_wide = 32'(live_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_id[i]    <= '0;
        slot_type[i]  <= '0;
        slot_state[i] <= OBJ_GONE;
        slot_refs[i]  <= '0;
      end
      live_objects <= '0;
      next_id      <= ID_W'(1);
    end else if (cmd.exec) begin
      if (wr) begin
        slot_id[idx]    <= n_id;
        slot_type[idx]  <= n_type;
        slot_state[idx] <= n_state;
        slot_refs[idx]  <= n_refs;
      end
      live_objects <= live_next;
      next_id      <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op    <= opcode;
      req_type  <= object_type;
      match_vec <= match_vec_next;
      free_vec  <= free_vec_next;
    end
    if (cmd.exec) begin
      rsp_data.status     <= sts;
      rsp_data.freed      <= fr;
      rsp_data.live_count <= live_wide[LIVE_W-1:0];
      if (sts != STS_OK || fr) begin
        rsp_data.result_id    <= '0;
        rsp_data.result_type  <= '0;
        rsp_data.result_state <= OBJ_GONE;
        rsp_data.result_refs  <= '0;
      end else begin
        rsp_data.result_id    <= n_id;
        rsp_data.result_type  <= n_type;
        rsp_data.result_state <= n_state;
        rsp_data.result_refs  <= refs_wide[REFS_W-1:0];
      end
    end
  end
endmodule
